// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tlfm_pkg.sv
// ----------------------------------------------------------------------------
// tlfm_pkg
// Constants and codes of the tank level filter monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlfm_pkg;

   localparam int DIST_BITS   = 10;
   localparam int Q_BITS      = 8;
   localparam int FD_W        = DIST_BITS + Q_BITS;
   localparam int ERR_W       = 17;
   localparam int TREND_W     = 5;
   localparam int TREND_LIMIT = 10;
   localparam int CFG_IDX_W   = 3;
   localparam int CFG_DATA_W  = 24;
   localparam int MODE_W      = 2;
   localparam int ALPHA_W     = 16;
   localparam int NOISE_W     = 24;
   localparam int LIMIT_W     = 10;
   localparam int SHAPE_W     = 16;
   localparam int LEVEL_W     = 2;
   localparam int VOL_W       = 32;

   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = 64;
   localparam int DIV_N_W = 48;
   localparam int DIV_D_W = 26;

   localparam logic [ERR_W-1:0] ERR_ONE   = ERR_W'(65536);
   localparam logic [ERR_W-1:0] ERR_TENTH = ERR_W'(6554);
   localparam logic [MUL_B_W-1:0] PI_Q20  = MUL_B_W'(3294199);
   localparam logic [DIV_D_W-1:0] VOL_DIV = DIV_D_W'(1000);
   localparam logic [PROD_W-1:0] ROUND_Q16 = PROD_W'(32768);
   localparam logic [PROD_W-1:0] ROUND_PRISM = PROD_W'(500);
   localparam logic [PROD_W-1:0] ROUND_CYL = PROD_W'(500) << 20;

   localparam logic signed [TREND_W-1:0] TREND_HI = TREND_W'(TREND_LIMIT);
   localparam logic signed [TREND_W-1:0] TREND_LO = -TREND_W'(TREND_LIMIT);

   localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_NOISE       = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST    = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_VOL_MODEL   = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_SHAPE       = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_TANK_HEIGHT = 3'd7;

   localparam logic [MODE_W-1:0] MODE_EXP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_KALMAN = 2'd2;
   localparam logic [MODE_W-1:0] VOL_CYL     = 2'd1;
   localparam logic [MODE_W-1:0] VOL_PRISM   = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_OK   = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

endpackage

// File: sv/tlfm_if.sv
// ----------------------------------------------------------------------------
// tlfm_req_if / tlfm_rsp_if
// Valid/ready channels for distance requests and level results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlfm_req_if import tlfm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DIST_BITS-1:0] distance_cm;
   modport source (output valid, output distance_cm, input ready);
   modport sink   (input valid, input distance_cm, output ready);
endinterface

interface tlfm_rsp_if import tlfm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [LEVEL_W-1:0]      level_state;
   logic [FD_W-1:0]         filtered_distance_q8;
   logic signed [VOL_W-1:0] volume_q8;
   modport source (output valid, output level_state, output filtered_distance_q8,
                   output volume_q8, input ready);
   modport sink   (input valid, input level_state, input filtered_distance_q8,
                   input volume_q8, output ready);
endinterface

// File: sv/tlfm_mul.sv
// ----------------------------------------------------------------------------
// tlfm_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlfm_mul import tlfm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] op_a,
   input  logic [MUL_B_W-1:0] op_b,
   output logic               done,
   output logic [PROD_W-1:0]  prod
);

   localparam int CNT_W = $clog2(MUL_B_W);

   logic [PROD_W-1:0]  a_ff;
   logic [MUL_B_W-1:0] b_ff;
   logic [PROD_W-1:0]  acc_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(MUL_B_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= PROD_W'(op_a);
         b_ff   <= op_b;
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff   <= a_ff << 1;
         b_ff   <= b_ff >> 1;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// File: sv/tlfm_div.sv
// ----------------------------------------------------------------------------
// tlfm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlfm_div import tlfm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_N_W);

   logic [DIV_N_W-1:0] dd_ff;
   logic [DIV_N_W-1:0] q_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W-1:0] d_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIV_D_W:0]   trial;
   logic               fits;

   assign trial = {rem_ff, dd_ff[DIV_N_W-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(DIV_N_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dd_ff  <= dividend;
         d_ff   <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? DIV_D_W'(trial - {1'b0, d_ff}) : trial[DIV_D_W-1:0];
         q_ff   <= {q_ff[DIV_N_W-2:0], fits};
         dd_ff  <= dd_ff << 1;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: sv/tank_level_filter_monitor.sv
// ----------------------------------------------------------------------------
// tank_level_filter_monitor
// Smooths ranger distances, tracks the level state and models tank volume.
// ----------------------------------------------------------------------------
// channel  dir  handshake    payload
// req_ch   in   valid/ready  distance_cm
// rsp_ch   out  valid/ready  level_state, filtered_distance_q8, volume_q8
// csr_*    in   csr_wr_en    csr_index, csr_wdata
//
// One request at a time. Filtering uses the serial multiplier and divider:
// exponential two multiplies, Kalman a divide and three multiplies. Volume
// uses a multiply and a divide for prism, three multiplies and a divide for
// cylinder, neither for raw. A new request is taken while a result still waits
// on rsp_ch. Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tank_level_filter_monitor import tlfm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tlfm_req_if.sink              req_ch,
   tlfm_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_GAIN  = 4'd1;
   localparam logic [3:0] S_ERR   = 4'd2;
   localparam logic [3:0] S_BL1   = 4'd3;
   localparam logic [3:0] S_BL2   = 4'd4;
   localparam logic [3:0] S_LEVEL = 4'd5;
   localparam logic [3:0] S_V1    = 4'd6;
   localparam logic [3:0] S_V2    = 4'd7;
   localparam logic [3:0] S_V3    = 4'd8;
   localparam logic [3:0] S_VDIV  = 4'd9;
   localparam logic [3:0] S_FIN   = 4'd10;

   // configuration
   logic [MODE_W-1:0]  mode_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [NOISE_W-1:0] noise_ff;
   logic [LIMIT_W-1:0] min_ff;
   logic [LIMIT_W-1:0] max_ff;
   logic [MODE_W-1:0]  vmodel_ff;
   logic [SHAPE_W-1:0] shape_ff;
   logic [LIMIT_W-1:0] height_ff;

   // filter state
   logic                      seen_ff,   seen_in;
   logic [FD_W-1:0]           smooth_ff, smooth_in;
   logic [ERR_W-1:0]          err_ff,    err_in;
   logic signed [TREND_W-1:0] trend_ff,  trend_in;
   logic [LEVEL_W-1:0]        level_ff,  level_in;

   // sequencer and datapath
   logic [3:0]         state_ff,    state_in;
   logic               mstart_ff,   mstart_in;
   logic               dstart_ff,   dstart_in;
   logic [FD_W-1:0]    t_ff,        t_in;
   logic [ERR_W-1:0]   w_ff,        w_in;
   logic [PROD_W-1:0]  acc_ff,      acc_in;
   logic [FD_W-1:0]    val_ff,      val_in;
   logic [FD_W-1:0]    mag_ff,      mag_in;
   logic               neg_ff,      neg_in;
   logic [DIV_N_W-1:0] v_ff,        v_in;
   logic               rsp_vld_ff,  rsp_vld_in;
   logic [LEVEL_W-1:0] rsp_lvl_ff,  rsp_lvl_in;
   logic [FD_W-1:0]    rsp_fd_ff,   rsp_fd_in;
   logic [VOL_W-1:0]   rsp_vol_ff,  rsp_vol_in;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic               mul_done;
   logic [PROD_W-1:0]  mul_p;
   logic [DIV_N_W-1:0] div_n;
   logic [DIV_D_W-1:0] div_d;
   logic               div_done;
   logic [DIV_N_W-1:0] div_q;

   logic               req_fire;
   logic [ERR_W-1:0]   w_inv;
   logic [PROD_W-1:0]  blend_sum;
   logic [FD_W:0]      h;
   logic               below, above;
   logic [DIV_N_W-1:0] v_sat;
   logic [VOL_W-1:0]   vol_out;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign w_inv     = ERR_ONE - w_ff;
   assign blend_sum = acc_ff + mul_p + ROUND_Q16;
   assign h         = {1'b0, height_ff, {Q_BITS{1'b0}}} - {1'b0, val_ff};
   assign below     = val_ff < {min_ff, {Q_BITS{1'b0}}};
   assign above     = val_ff > {max_ff, {Q_BITS{1'b0}}};

   always_comb begin
      case (state_ff)
         S_ERR:   begin mul_a = MUL_A_W'(err_ff);   mul_b = MUL_B_W'(w_inv); end
         S_BL1:   begin mul_a = MUL_A_W'(smooth_ff); mul_b = MUL_B_W'(w_inv); end
         S_BL2:   begin mul_a = MUL_A_W'(t_ff);     mul_b = MUL_B_W'(w_ff); end
         S_V1:    begin mul_a = MUL_A_W'(shape_ff); mul_b = MUL_B_W'(shape_ff); end
         S_V2:    begin
            mul_a = (vmodel_ff == VOL_CYL) ? acc_ff[MUL_A_W-1:0] : MUL_A_W'(shape_ff);
            mul_b = MUL_B_W'(mag_ff);
         end
         S_V3:    begin mul_a = acc_ff[MUL_A_W-1:0]; mul_b = PI_Q20; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      if (state_ff == S_GAIN) begin
         div_n = DIV_N_W'({err_ff, 16'd0});
         div_d = DIV_D_W'(err_ff) + DIV_D_W'(noise_ff);
      end else begin
         div_n = acc_ff[DIV_N_W-1:0];
         div_d = VOL_DIV;
      end
   end

   tlfm_mul u_mul (
      .clock (clock), .reset (reset), .start (mstart_ff),
      .op_a  (mul_a), .op_b  (mul_b), .done  (mul_done), .prod (mul_p)
   );

   tlfm_div u_div (
      .clock    (clock), .reset (reset), .start (dstart_ff),
      .dividend (div_n), .divisor (div_d), .done (div_done), .quotient (div_q)
   );

   // saturate and sign the volume
   always_comb begin
      if (neg_ff) begin
         v_sat   = (v_ff > DIV_N_W'(33'h1_0000_0000 >> 1)) ?
                   DIV_N_W'(33'h1_0000_0000 >> 1) : v_ff;
         vol_out = VOL_W'(~v_sat + 1'b1);
      end else begin
         v_sat   = (v_ff > DIV_N_W'(32'h7FFF_FFFF)) ? DIV_N_W'(32'h7FFF_FFFF) : v_ff;
         vol_out = v_sat[VOL_W-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      mstart_in  = 1'b0;
      dstart_in  = 1'b0;
      t_in       = t_ff;
      w_in       = w_ff;
      acc_in     = acc_ff;
      val_in     = val_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      v_in       = v_ff;
      seen_in    = seen_ff;
      smooth_in  = smooth_ff;
      err_in     = err_ff;
      trend_in   = trend_ff;
      level_in   = level_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      rsp_lvl_in = rsp_lvl_ff;
      rsp_fd_in  = rsp_fd_ff;
      rsp_vol_in = rsp_vol_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               t_in     = {req_ch.distance_cm, {Q_BITS{1'b0}}};
               val_in   = t_in;
               state_in = S_LEVEL;
               if (seen_ff && mode_ff == MODE_EXP) begin
                  w_in      = ERR_W'(alpha_ff);
                  state_in  = S_BL1;
                  mstart_in = 1'b1;
               end else if (seen_ff && mode_ff == MODE_KALMAN) begin
                  if (err_ff == '0) begin
                     err_in = ERR_TENTH;
                  end else begin
                     state_in  = S_GAIN;
                     dstart_in = 1'b1;
                  end
               end
            end
         end
         S_GAIN: begin
            if (div_done) begin
               w_in      = div_q[ERR_W-1:0];
               state_in  = S_ERR;
               mstart_in = 1'b1;
            end
         end
         S_ERR: begin
            if (mul_done) begin
               err_in    = mul_p[16 +: ERR_W];
               state_in  = S_BL1;
               mstart_in = 1'b1;
            end
         end
         S_BL1: begin
            if (mul_done) begin
               acc_in    = mul_p;
               state_in  = S_BL2;
               mstart_in = 1'b1;
            end
         end
         S_BL2: begin
            if (mul_done) begin
               val_in   = blend_sum[16 +: FD_W];
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            smooth_in = val_ff;
            seen_in   = 1'b1;
            if (below) begin
               if (trend_ff < TREND_LO || !seen_ff) level_in = LEVEL_HIGH;
               else                                 trend_in = trend_ff - 1'b1;
            end else if (above) begin
               if (trend_ff > TREND_HI || !seen_ff) level_in = LEVEL_LOW;
               else                                 trend_in = trend_ff + 1'b1;
            end else begin
               trend_in = '0;
               level_in = LEVEL_OK;
            end
            neg_in = h[FD_W];
            mag_in = h[FD_W] ? FD_W'(-h) : h[FD_W-1:0];
            case (vmodel_ff)
               VOL_CYL: begin
                  state_in  = S_V1;
                  mstart_in = 1'b1;
               end
               VOL_PRISM: begin
                  state_in  = S_V2;
                  mstart_in = 1'b1;
               end
               default: begin
                  v_in     = DIV_N_W'(mag_in);
                  state_in = S_FIN;
               end
            endcase
         end
         S_V1: begin
            if (mul_done) begin
               acc_in    = mul_p;
               state_in  = S_V2;
               mstart_in = 1'b1;
            end
         end
         S_V2: begin
            if (mul_done) begin
               if (vmodel_ff == VOL_CYL) begin
                  if (mul_p[PROD_W-1:40] != '0) begin
                     v_in     = DIV_N_W'(1) << 40;
                     state_in = S_FIN;
                  end else begin
                     acc_in    = mul_p;
                     state_in  = S_V3;
                     mstart_in = 1'b1;
                  end
               end else begin
                  acc_in    = mul_p + ROUND_PRISM;
                  state_in  = S_VDIV;
                  dstart_in = 1'b1;
               end
            end
         end
         S_V3: begin
            if (mul_done) begin
               acc_in    = (mul_p + ROUND_CYL) >> 20;
               state_in  = S_VDIV;
               dstart_in = 1'b1;
            end
         end
         S_VDIV: begin
            if (div_done) begin
               v_in     = div_q;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in = 1'b1;
               rsp_lvl_in = level_ff;
               rsp_fd_in  = smooth_ff;
               rsp_vol_in = vol_out;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wr_en && csr_index == REG_FILTER_MODE && csr_wdata[MODE_W-1:0] == MODE_KALMAN) begin
         err_in = ERR_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mstart_ff  <= 1'b0;
         dstart_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         seen_ff    <= 1'b0;
         smooth_ff  <= '0;
         err_ff     <= '0;
         trend_ff   <= '0;
         level_ff   <= LEVEL_OK;
      end else begin
         state_ff   <= state_in;
         mstart_ff  <= mstart_in;
         dstart_ff  <= dstart_in;
         rsp_vld_ff <= rsp_vld_in;
         seen_ff    <= seen_in;
         smooth_ff  <= smooth_in;
         err_ff     <= err_in;
         trend_ff   <= trend_in;
         level_ff   <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff       <= t_in;
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      val_ff     <= val_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      v_ff       <= v_in;
      rsp_lvl_ff <= rsp_lvl_in;
      rsp_fd_ff  <= rsp_fd_in;
      rsp_vol_ff <= rsp_vol_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         alpha_ff  <= ALPHA_W'(16384);
         noise_ff  <= NOISE_W'(65536);
         min_ff    <= LIMIT_W'(10);
         max_ff    <= LIMIT_W'(100);
         vmodel_ff <= '0;
         shape_ff  <= '0;
         height_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FILTER_MODE: mode_ff   <= csr_wdata[MODE_W-1:0];
            REG_ALPHA:       alpha_ff  <= csr_wdata[ALPHA_W-1:0];
            REG_NOISE:       noise_ff  <= csr_wdata[NOISE_W-1:0];
            REG_MIN_DIST:    min_ff    <= csr_wdata[LIMIT_W-1:0];
            REG_MAX_DIST:    max_ff    <= csr_wdata[LIMIT_W-1:0];
            REG_VOL_MODEL:   vmodel_ff <= csr_wdata[MODE_W-1:0];
            REG_SHAPE:       shape_ff  <= csr_wdata[SHAPE_W-1:0];
            REG_TANK_HEIGHT: height_ff <= csr_wdata[LIMIT_W-1:0];
            default:         ;
         endcase
      end
   end

   assign req_ch.ready                = (state_ff == S_IDLE);
   assign rsp_ch.valid                = rsp_vld_ff;
   assign rsp_ch.level_state          = rsp_lvl_ff;
   assign rsp_ch.filtered_distance_q8 = rsp_fd_ff;
   assign rsp_ch.volume_q8            = rsp_vol_ff;

endmodule

// File: sv/tlfm_checker.sv
// ----------------------------------------------------------------------------
// tlfm_checker
// Port-level checks on the tank level filter monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlfm_checker import tlfm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LEVEL_W-1:0] rsp_level,
   input logic [FD_W-1:0]    rsp_fd
);

   `ASSERT_CLK(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")
   `ASSERT_CLK_RST(a_one_at_a_time, clock, reset, (req_valid && req_ready) |=> !req_ready, "second request taken while busy")
   `ASSERT_CLK_RST(a_level_code, clock, reset, rsp_valid |-> (rsp_level == LEVEL_OK || rsp_level == LEVEL_LOW || rsp_level == LEVEL_HIGH), "bad level code")
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped")
   `ASSERT_CLK_RST(a_rsp_stable, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_fd), "result changed while stalled")

endmodule

bind tank_level_filter_monitor tlfm_checker u_tlfm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_level (rsp_ch.level_state),
   .rsp_fd    (rsp_ch.filtered_distance_q8)
);
